// ----- rtl/core/frzg_pkg.sv -----
// Shared types, constants and helpers for the frame rate zone governor.
package frzg_pkg;

	localparam int COL_LIMIT_DFLT = 16;
	localparam int ROW_LIMIT_DFLT = 16;

	localparam int RATE_W = 20;
	localparam int CNT_W  = 5;
	localparam int ZONE_W = 9;
	localparam int PROD_W = 2 * CNT_W;
	localparam int IDX_W  = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MULTI_USERS = 3'd0;
	localparam logic [IDX_W-1:0] REG_AUTO_ADJUST = 3'd1;
	localparam logic [IDX_W-1:0] REG_RATE_TARGET = 3'd2;
	localparam logic [IDX_W-1:0] REG_RATE_BAND   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_COLS    = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX_ROWS    = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAN_COLS    = 3'd6;
	localparam logic [IDX_W-1:0] REG_MAN_ROWS    = 3'd7;

	localparam logic [RATE_W-1:0] RATE_TARGET_RST = 20'd5120;
	localparam logic [RATE_W-1:0] RATE_BAND_RST   = 20'd1024;
	localparam logic [CNT_W-1:0]  MAX_COLS_RST    = 5'd16;
	localparam logic [CNT_W-1:0]  MAX_ROWS_RST    = 5'd4;

	typedef struct packed {
		logic              multiple_users;
		logic              auto_adjust;
		logic [RATE_W-1:0] rate_target;
		logic [RATE_W-1:0] rate_band;
		logic [CNT_W-1:0]  max_columns;
		logic [CNT_W-1:0]  max_rows;
		logic [CNT_W-1:0]  manual_columns;
		logic [CNT_W-1:0]  manual_rows;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic bal;
		logic div;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_bal;
		logic div_sel;
		logic div_done;
		logic out_free;
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_STEP = 5'b00010,
		S_BAL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	// limit a count to 1..hi
	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [PROD_W-1:0] v,
			input logic [CNT_W-1:0] hi);
		logic [CNT_W-1:0] res;
		if (v == '0) begin
			res = CNT_W'(1);
		end else if (v > PROD_W'(hi)) begin
			res = hi;
		end else begin
			res = v[CNT_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/frzg_cfg.sv -----
// Configuration register bank of the zone governor.
module frzg_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [frzg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [frzg_pkg::RATE_W-1:0]  cfg_data,
	output frzg_pkg::cfg_t               cfg
);
	import frzg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.multiple_users <= 1'b0;
			cfg_q.auto_adjust    <= 1'b1;
			cfg_q.rate_target    <= RATE_TARGET_RST;
			cfg_q.rate_band      <= RATE_BAND_RST;
			cfg_q.max_columns    <= MAX_COLS_RST;
			cfg_q.max_rows       <= MAX_ROWS_RST;
			cfg_q.manual_columns <= CNT_W'(1);
			cfg_q.manual_rows    <= CNT_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MULTI_USERS: cfg_q.multiple_users <= cfg_data[0];
				REG_AUTO_ADJUST: cfg_q.auto_adjust    <= cfg_data[0];
				REG_RATE_TARGET: cfg_q.rate_target    <= cfg_data;
				REG_RATE_BAND:   cfg_q.rate_band      <= cfg_data;
				REG_MAX_COLS:    cfg_q.max_columns    <= cfg_data[CNT_W-1:0];
				REG_MAX_ROWS:    cfg_q.max_rows       <= cfg_data[CNT_W-1:0];
				REG_MAN_COLS:    cfg_q.manual_columns <= cfg_data[CNT_W-1:0];
				REG_MAN_ROWS:    cfg_q.manual_rows    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/frzg_ctrl.sv -----
// Sequencing state machine of the zone governor.
module frzg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rate_valid,
	output logic              rate_stall,
	input  frzg_pkg::status_t sts,
	output frzg_pkg::cmd_t    cmd
);
	import frzg_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (rate_valid) begin
					cmd.load = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = sts.need_bal ? S_BAL : S_DONE;
			end
			S_BAL: begin
				cmd.bal = 1'b1;
				state_d = sts.div_sel ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for room in the output register
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rate_stall = (state_q != S_IDLE);

endmodule

// ----- rtl/core/frzg_dp.sv -----
// Datapath of the zone governor: grid step, rebalance divider, state and output word.
module frzg_dp #(
	parameter int COLUMN_LIMIT = frzg_pkg::COL_LIMIT_DFLT,
	parameter int ROW_LIMIT    = frzg_pkg::ROW_LIMIT_DFLT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  frzg_pkg::cfg_t               cfg,
	input  frzg_pkg::cmd_t               cmd,
	output frzg_pkg::status_t            sts,
	input  logic [frzg_pkg::RATE_W-1:0]  frame_rate,
	output logic                         grid_valid,
	input  logic                         grid_stall,
	output logic [frzg_pkg::CNT_W-1:0]   grid_columns,
	output logic [frzg_pkg::CNT_W-1:0]   grid_rows,
	output logic [frzg_pkg::ZONE_W-1:0]  zone_total,
	output logic                         grid_changed
);
	import frzg_pkg::*;

	localparam int LIM_W   = 7;
	localparam int DVS_W   = CNT_W + 1;
	localparam int DIV_N   = PROD_W;
	localparam int DCNT_W  = $clog2(DIV_N);
	localparam int CMP_W   = PROD_W + 2;

	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  wc_q, wr_q;
	logic              chg_q;
	logic [CNT_W-1:0]  col_q, row_q;
	logic [ZONE_W-1:0] applied_q;
	logic [PROD_W-1:0] dvd_q, quo_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_cols_q, out_rows_q;
	logic [ZONE_W-1:0] out_total_q;
	logic              out_chg_q;

	// effective maxima
	logic [CNT_W-1:0] maxc, maxr;

	always_comb begin
		if (cfg.max_columns == '0) begin
			maxc = CNT_W'(1);
		end else if (LIM_W'(cfg.max_columns) > LIM_W'(COLUMN_LIMIT)) begin
			maxc = CNT_W'(COLUMN_LIMIT);
		end else begin
			maxc = cfg.max_columns;
		end
		if (cfg.max_rows == '0) begin
			maxr = CNT_W'(1);
		end else if (LIM_W'(cfg.max_rows) > LIM_W'(ROW_LIMIT)) begin
			maxr = CNT_W'(ROW_LIMIT);
		end else begin
			maxr = cfg.max_rows;
		end
	end

	// mode select and hysteresis step
	logic [RATE_W:0]  lo_sum, hi_sum;
	logic             slow, fast;
	logic [CNT_W-1:0] step_c, step_r, cc, rr, mc, mr;
	logic             step_chg;

	assign lo_sum = {1'b0, rate_q} + {1'b0, cfg.rate_band};
	assign hi_sum = {1'b0, cfg.rate_target} + {1'b0, cfg.rate_band};
	assign slow   = lo_sum < {1'b0, cfg.rate_target};
	assign fast   = {1'b0, rate_q} > hi_sum;
	assign cc     = clamp_cnt(PROD_W'(col_q), maxc);
	assign rr     = clamp_cnt(PROD_W'(row_q), maxr);
	assign mc     = clamp_cnt(PROD_W'(cfg.manual_columns), maxc);
	assign mr     = clamp_cnt(PROD_W'(cfg.manual_rows), maxr);

	always_comb begin
		step_c   = cc;
		step_r   = rr;
		step_chg = (cc != col_q) || (rr != row_q);
		if (!cfg.multiple_users) begin
			step_c   = CNT_W'(1);
			step_r   = CNT_W'(1);
			step_chg = (applied_q != ZONE_W'(1));
		end else if (!cfg.auto_adjust) begin
			step_c   = mc;
			step_r   = mr;
			step_chg = (mc != col_q) || (mr != row_q);
		end else if (slow) begin
			if (cc > CNT_W'(1)) begin
				step_c   = cc - CNT_W'(1);
				step_chg = 1'b1;
			end else if (rr > CNT_W'(1)) begin
				step_r   = rr - CNT_W'(1);
				step_chg = 1'b1;
			end
		end else if (fast) begin
			if (cc < maxc) begin
				step_c   = cc + CNT_W'(1);
				step_chg = 1'b1;
			end else if (rr < maxr) begin
				step_r   = rr + CNT_W'(1);
				step_chg = 1'b1;
			end
		end
	end

	// aspect balance tests, ratio 1.5 as factors 3 and 2
	logic [PROD_W-1:0] cm, mrow, cr;
	logic [CMP_W-1:0]  cm2, cm3, mr2, mr3;
	logic              t_split, t_merge;

	assign cm      = PROD_W'(wc_q) * PROD_W'(maxr);
	assign mrow    = PROD_W'(maxc) * PROD_W'(wr_q);
	assign cr      = PROD_W'(wc_q) * PROD_W'(wr_q);
	assign cm2     = {1'b0, cm, 1'b0};
	assign mr2     = {1'b0, mrow, 1'b0};
	assign cm3     = CMP_W'(cm) + cm2;
	assign mr3     = CMP_W'(mrow) + mr2;
	assign t_split = (cm2 > mr3) && (wr_q < maxr);
	assign t_merge = (cm3 < mr2) && (wr_q > CNT_W'(1));

	// restoring divider, one quotient bit a cycle
	logic [DVS_W:0]    trial;
	logic              ge;
	logic [DVS_W-1:0]  rem_nx;
	logic [PROD_W-1:0] quo_nx;

	assign trial  = {rem_q, dvd_q[PROD_W-1]};
	assign ge     = trial >= {1'b0, dvs_q};
	assign rem_nx = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	assign quo_nx = {quo_q[PROD_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rate_q <= frame_rate;
		end
		if (cmd.step) begin
			wc_q  <= step_c;
			wr_q  <= step_r;
			chg_q <= step_chg;
		end
		if (cmd.bal && (t_split || t_merge)) begin
			dvd_q <= cr;
			quo_q <= '0;
			rem_q <= '0;
			cnt_q <= DCNT_W'(DIV_N - 1);
			if (t_split) begin
				dvs_q <= DVS_W'(wr_q) + DVS_W'(1);
				wr_q  <= wr_q + CNT_W'(1);
			end else begin
				dvs_q <= DVS_W'(wr_q) - DVS_W'(1);
				wr_q  <= wr_q - CNT_W'(1);
			end
		end
		if (cmd.div) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == '0) begin
				wc_q <= clamp_cnt(quo_nx, maxc);
			end
		end
		if (cmd.commit) begin
			out_cols_q  <= wc_q;
			out_rows_q  <= wr_q;
			out_total_q <= cr[ZONE_W-1:0];
			out_chg_q   <= chg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= CNT_W'(1);
			row_q       <= CNT_W'(1);
			applied_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				col_q <= wc_q;
				row_q <= wr_q;
				if (chg_q) begin
					applied_q <= cr[ZONE_W-1:0];
				end
				out_valid_q <= 1'b1;
			end else if (!grid_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.need_bal = cfg.multiple_users && cfg.auto_adjust && step_chg;
	assign sts.div_sel  = t_split || t_merge;
	assign sts.div_done = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || !grid_stall;

	assign grid_valid   = out_valid_q;
	assign grid_columns = out_cols_q;
	assign grid_rows    = out_rows_q;
	assign zone_total   = out_total_q;
	assign grid_changed = out_chg_q;

endmodule

// ----- rtl/core/frame_rate_zone_governor_core.sv -----
// Frame rate zone governor: one grid decision per measured frame rate word.
// Each frame_rate word produces one grid word (columns, rows, zone total, changed
// flag). A word passes the step state and goes to the output register when the
// grid is unchanged or not rate driven; a rate driven change also passes the
// balance test, and when the grid is rebalanced the one-bit-a-cycle restoring
// divider recomputes the columns after rows are split or merged. rate_stall stays
// high from acceptance until the word is in the output register; a finished word
// waits there while the next frame is processed. Configuration must be written
// by the user only while no frame is in flight; the block does not enforce this.
// The zone total is columns times rows, kept to nine bits.
module frame_rate_zone_governor_core #(
	parameter int COLUMN_LIMIT = frzg_pkg::COL_LIMIT_DFLT,
	parameter int ROW_LIMIT    = frzg_pkg::ROW_LIMIT_DFLT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [frzg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [frzg_pkg::RATE_W-1:0]  cfg_data,
	input  logic                         rate_valid,
	output logic                         rate_stall,
	input  logic [frzg_pkg::RATE_W-1:0]  frame_rate,
	output logic                         grid_valid,
	input  logic                         grid_stall,
	output logic [frzg_pkg::CNT_W-1:0]   grid_columns,
	output logic [frzg_pkg::CNT_W-1:0]   grid_rows,
	output logic [frzg_pkg::ZONE_W-1:0]  zone_total,
	output logic                         grid_changed
);
	import frzg_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	frzg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	frzg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rate_valid (rate_valid),
		.rate_stall (rate_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	frzg_dp #(
		.COLUMN_LIMIT (COLUMN_LIMIT),
		.ROW_LIMIT    (ROW_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.frame_rate   (frame_rate),
		.grid_valid   (grid_valid),
		.grid_stall   (grid_stall),
		.grid_columns (grid_columns),
		.grid_rows    (grid_rows),
		.zone_total   (zone_total),
		.grid_changed (grid_changed)
	);

`ifndef SYNTHESIS
	// an accepted word keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rate_valid && !rate_stall |=> rate_stall)
		else $error("input open right after accepting a word");

	a_grid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		grid_valid |-> (grid_columns != '0) && (grid_rows != '0))
		else $error("grid word with zero columns or rows");

	a_total_match: assert property (@(posedge clk) disable iff (!arst_n)
		grid_valid |-> zone_total == ZONE_W'(PROD_W'(grid_columns) * PROD_W'(grid_rows)))
		else $error("zone total does not match grid");

	// a commit only happens into a free output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("output word overwritten");
`endif

endmodule
